// File: sv/cba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cba_pkg: shared types and constants of the CPU bitmap allocator
// Micro-step codes, condition codes, control word and datapath flags.
// ----------------------------------------------------------------------------
package cba_pkg;

    localparam int WORDS_DEF   = 8;
    localparam int BITS_PER_W  = 64;
    localparam int START_W     = 3;
    localparam int CPU_W       = 9;
    localparam int WIU_W       = 4;
    localparam int LIMIT_W     = 10;
    localparam int STATUS_W    = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;

    localparam logic [WIU_W-1:0]   WIU_RESET   = 4'd8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd512;

    // configuration register indexes
    localparam logic CFG_WORDS_IN_USE = 1'b0;
    localparam logic CFG_CPU_LIMIT    = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVAL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;

    typedef enum logic [3:0] {
        STP_FETCH,
        STP_CHK,
        STP_MOD,
        STP_READ,
        STP_TEST,
        STP_EMIT,
        STP_TAKE,
        STP_VAC,
        STP_VSET
    } step_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_OP_VAC,
        C_N_ZERO,
        C_W_GE,
        C_HIT,
        C_MORE,
        C_BAD,
        C_OUT_BUSY
    } cond_t;

    typedef enum logic [1:0] {
        RS_W,
        RS_SCAN,
        RS_VAC
    } rdsel_t;

    typedef struct packed {
        cond_t  stay_cond;
        cond_t  jmp_cond;
        step_t  jmp_target;
        rdsel_t rd_sel;
        logic   ld_in;
        logic   mod_sub;
        logic   scan;
        logic   take;
        logic   vchk;
        logic   vset;
        logic   emit;
    } ctrl_t;

    typedef struct packed {
        logic no_in;
        logic op_vac;
        logic n_zero;
        logic w_ge;
        logic hit;
        logic more;
        logic bad;
        logic out_busy;
    } flags_t;

endpackage
`default_nettype wire

// File: sv/cpu_bitmap_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_bitmap_allocator: free-CPU bitmap with rotating first-free pick
// Pick: CHK, MOD (start word modulo words in use), READ, TEST (scans words
// in use from the start word), TAKE when a CPU is found, then EMIT; with
// no words in use CHK goes straight to EMIT. Vacate: VAC, VSET unless
// rejected, then EMIT. One item at a time; FETCH takes the next after EMIT.
// Reset: synchronous; all CPUs busy, 8 words, limit 512.
// ----------------------------------------------------------------------------
module cpu_bitmap_allocator #(
    parameter int WORDS = cba_pkg::WORDS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [cba_pkg::S_TDATA_W-1:0]    s_tdata,   // start_word[2:0], cpu_index[11:3]
    input  wire                              s_tuser,   // operation[0]
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [cba_pkg::M_TDATA_W-1:0]    m_tdata,   // status[1:0], cpu_id[10:2],
                                                        // next_start[13:11]
    input  wire                              cfg_we,
    input  wire                              cfg_index,
    input  wire  [cba_pkg::CFG_DATA_W-1:0]   cfg_data
);

    cba_pkg::ctrl_t  ctrl;
    cba_pkg::flags_t flags;

    cba_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    cba_datapath #(
        .WORDS (WORDS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .flags     (flags),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
`default_nettype wire

// File: sv/cba_ucode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cba_ucode: microprogram ROM
// One control word per step; stay takes priority over jump, else fall through.
// ----------------------------------------------------------------------------
module cba_ucode (
    input  wire cba_pkg::step_t addr,
    output cba_pkg::ctrl_t      ctrl
);

    always_comb begin
        ctrl            = '0;
        ctrl.stay_cond  = cba_pkg::C_NEVER;
        ctrl.jmp_cond   = cba_pkg::C_NEVER;
        ctrl.jmp_target = cba_pkg::STP_FETCH;
        ctrl.rd_sel     = cba_pkg::RS_W;
        case (addr)
            cba_pkg::STP_FETCH: begin
                ctrl.stay_cond  = cba_pkg::C_NO_IN;
                ctrl.jmp_cond   = cba_pkg::C_OP_VAC;
                ctrl.jmp_target = cba_pkg::STP_VAC;
                ctrl.ld_in      = 1'b1;
            end
            cba_pkg::STP_CHK: begin
                ctrl.jmp_cond   = cba_pkg::C_N_ZERO;
                ctrl.jmp_target = cba_pkg::STP_EMIT;
            end
            cba_pkg::STP_MOD: begin
                ctrl.stay_cond = cba_pkg::C_W_GE;
                ctrl.mod_sub   = 1'b1;
            end
            cba_pkg::STP_READ: begin
                ctrl.rd_sel = cba_pkg::RS_W;
            end
            cba_pkg::STP_TEST: begin
                ctrl.stay_cond  = cba_pkg::C_MORE;
                ctrl.jmp_cond   = cba_pkg::C_HIT;
                ctrl.jmp_target = cba_pkg::STP_TAKE;
                ctrl.rd_sel     = cba_pkg::RS_SCAN;
                ctrl.scan       = 1'b1;
            end
            cba_pkg::STP_EMIT: begin
                ctrl.stay_cond  = cba_pkg::C_OUT_BUSY;
                ctrl.jmp_cond   = cba_pkg::C_ALWAYS;
                ctrl.jmp_target = cba_pkg::STP_FETCH;
                ctrl.emit       = 1'b1;
            end
            cba_pkg::STP_TAKE: begin
                ctrl.jmp_cond   = cba_pkg::C_ALWAYS;
                ctrl.jmp_target = cba_pkg::STP_EMIT;
                ctrl.take       = 1'b1;
            end
            cba_pkg::STP_VAC: begin
                ctrl.jmp_cond   = cba_pkg::C_BAD;
                ctrl.jmp_target = cba_pkg::STP_EMIT;
                ctrl.rd_sel     = cba_pkg::RS_VAC;
                ctrl.vchk       = 1'b1;
            end
            cba_pkg::STP_VSET: begin
                ctrl.jmp_cond   = cba_pkg::C_ALWAYS;
                ctrl.jmp_target = cba_pkg::STP_EMIT;
                ctrl.vset       = 1'b1;
            end
            default: begin
                ctrl.jmp_cond   = cba_pkg::C_ALWAYS;
                ctrl.jmp_target = cba_pkg::STP_FETCH;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: sv/cba_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cba_seq: step counter and branch unit
// Holds the step counter, reads the ROM and resolves stay / jump / next.
// ----------------------------------------------------------------------------
module cba_seq (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire cba_pkg::flags_t flags,
    output cba_pkg::ctrl_t   ctrl
);

    cba_pkg::step_t pc_reg;
    cba_pkg::step_t pc_next;
    logic           stay;
    logic           jump;

    cba_ucode u_ucode (
        .addr (pc_reg),
        .ctrl (ctrl)
    );

    function automatic logic cond_eval(input cba_pkg::cond_t c, input cba_pkg::flags_t f);
        logic r;
        begin
            case (c)
                cba_pkg::C_NEVER:    r = 1'b0;
                cba_pkg::C_ALWAYS:   r = 1'b1;
                cba_pkg::C_NO_IN:    r = f.no_in;
                cba_pkg::C_OP_VAC:   r = f.op_vac;
                cba_pkg::C_N_ZERO:   r = f.n_zero;
                cba_pkg::C_W_GE:     r = f.w_ge;
                cba_pkg::C_HIT:      r = f.hit;
                cba_pkg::C_MORE:     r = f.more;
                cba_pkg::C_BAD:      r = f.bad;
                cba_pkg::C_OUT_BUSY: r = f.out_busy;
                default:             r = 1'b0;
            endcase
            return r;
        end
    endfunction

    always_comb begin
        stay = cond_eval(ctrl.stay_cond, flags);
        jump = cond_eval(ctrl.jmp_cond, flags);
        if (stay) begin
            pc_next = pc_reg;
        end else if (jump) begin
            pc_next = ctrl.jmp_target;
        end else begin
            pc_next = cba_pkg::step_t'(pc_reg + 4'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= cba_pkg::STP_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/cba_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cba_datapath: bitmap memory, scan registers and result stage
// Driven by the control word; reports branch flags back to the sequencer.
// ----------------------------------------------------------------------------
module cba_datapath #(
    parameter int WORDS = cba_pkg::WORDS_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire cba_pkg::ctrl_t                  ctrl,
    output cba_pkg::flags_t                      flags,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [cba_pkg::S_TDATA_W-1:0]        s_tdata,
    input  wire                                  s_tuser,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [cba_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire                                  cfg_we,
    input  wire                                  cfg_index,
    input  wire  [cba_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int WW = (WORDS > 1) ? $clog2(WORDS) : 1;   // word address
    localparam int NW = $clog2(WORDS + 1);                   // word count
    localparam int WX = (WW > cba_pkg::START_W) ? WW : cba_pkg::START_W;
    localparam int CW = (WX > NW) ? WX : NW;                 // compare width
    localparam int BW = $clog2(cba_pkg::BITS_PER_W);

    logic [cba_pkg::BITS_PER_W-1:0] mem [WORDS];
    logic [WORDS-1:0]               valid_reg;
    logic [cba_pkg::BITS_PER_W-1:0] rd_data_reg;
    logic                           rd_ok_reg;

    logic [cba_pkg::WIU_W-1:0]      wiu_reg;
    logic [cba_pkg::LIMIT_W-1:0]    limit_reg;

    logic [WX-1:0]                  w_reg;
    logic [WW-1:0]                  cnt_reg;
    logic [cba_pkg::CPU_W-1:0]      cpu_reg;
    logic [cba_pkg::STATUS_W-1:0]   status_reg;
    logic [cba_pkg::CPU_W-1:0]      id_reg;
    logic [cba_pkg::START_W-1:0]    next_reg;
    logic                           m_tvalid_reg;
    logic [cba_pkg::M_TDATA_W-1:0]  m_tdata_reg;

    logic [NW-1:0]                  n;
    logic [NW-1:0]                  n_m1;
    logic [WX-1:0]                  w_inc;
    logic [WX-1:0]                  vw;
    logic [WW-1:0]                  rd_addr;
    logic [WW-1:0]                  wr_addr;
    logic [cba_pkg::BITS_PER_W-1:0] wr_data;
    logic                           wr_en;
    logic [cba_pkg::BITS_PER_W-1:0] word;
    logic [cba_pkg::BITS_PER_W-1:0] iso;
    logic [cba_pkg::BITS_PER_W-1:0] cleared;
    logic [BW-1:0]                  bit_idx;
    logic                           accept;
    logic                           out_busy;

    always_comb begin
        if (32'(wiu_reg) > WORDS) begin
            n = NW'(WORDS);
        end else begin
            n = NW'(wiu_reg);
        end
        n_m1 = n - NW'(1);
        if (CW'(w_reg) == CW'(n_m1)) begin
            w_inc = '0;
        end else begin
            w_inc = w_reg + WX'(1);
        end
        vw = WX'(cpu_reg[cba_pkg::CPU_W-1:BW]);
        word = rd_ok_reg ? rd_data_reg : '0;
        // isolate lowest set bit and encode it
        iso     = word & (~word + 64'd1);
        cleared = word & (word - 64'd1);
        bit_idx = '0;
        for (int i = 0; i < cba_pkg::BITS_PER_W; i++) begin
            if (iso[i]) begin
                bit_idx = bit_idx | BW'(i);
            end
        end
    end

    // no item taken while reset is held
    assign s_tready = ctrl.ld_in & aresetn;
    assign accept   = s_tvalid & s_tready;
    assign out_busy = m_tvalid_reg & ~m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        flags.no_in    = ~s_tvalid;
        flags.op_vac   = s_tuser;
        flags.n_zero   = (n == '0);
        flags.w_ge     = (CW'(w_reg) >= CW'(n));
        flags.hit      = (word != '0);
        flags.more     = (word == '0) && (NW'(cnt_reg) != n_m1);
        flags.bad      = ({1'b0, cpu_reg} >= limit_reg) || (CW'(vw) >= CW'(n));
        flags.out_busy = out_busy;
    end

    always_comb begin
        case (ctrl.rd_sel)
            cba_pkg::RS_W:    rd_addr = w_reg[WW-1:0];
            cba_pkg::RS_SCAN: rd_addr = flags.more ? w_inc[WW-1:0] : w_reg[WW-1:0];
            cba_pkg::RS_VAC:  rd_addr = vw[WW-1:0];
            default:          rd_addr = w_reg[WW-1:0];
        endcase
        wr_en = ctrl.take | ctrl.vset;
        if (ctrl.vset) begin
            wr_addr = vw[WW-1:0];
            wr_data = word | (64'd1 << cpu_reg[BW-1:0]);
        end else begin
            wr_addr = w_reg[WW-1:0];
            wr_data = cleared;
        end
    end

    // bitmap store; an unwritten word reads as no CPU free
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_ok_reg   <= valid_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wiu_reg   <= cba_pkg::WIU_RESET;
            limit_reg <= cba_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                cba_pkg::CFG_WORDS_IN_USE: wiu_reg   <= cfg_data[cba_pkg::WIU_W-1:0];
                cba_pkg::CFG_CPU_LIMIT:    limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            w_reg      <= WX'(s_tdata[cba_pkg::START_W-1:0]);
            next_reg   <= s_tdata[cba_pkg::START_W-1:0];
            cpu_reg    <= s_tdata[cba_pkg::START_W +: cba_pkg::CPU_W];
            status_reg <= cba_pkg::ST_NOSPACE;
            id_reg     <= '0;
            cnt_reg    <= '0;
        end
        if (ctrl.mod_sub && flags.w_ge) begin
            w_reg <= WX'(CW'(w_reg) - CW'(n));
        end
        if (ctrl.scan && flags.more) begin
            w_reg   <= w_inc;
            cnt_reg <= cnt_reg + WW'(1);
        end
        if (ctrl.take) begin
            status_reg <= cba_pkg::ST_OK;
            id_reg     <= {w_reg[cba_pkg::START_W-1:0], bit_idx};
            next_reg   <= w_reg[cba_pkg::START_W-1:0];
        end
        if (ctrl.vchk && flags.bad) begin
            status_reg <= cba_pkg::ST_INVAL;
        end
        if (ctrl.vset) begin
            status_reg <= cba_pkg::ST_OK;
        end
    end

    // result stage: next item may be fetched while this one waits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.emit && !out_busy) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit && !out_busy) begin
            m_tdata_reg <= {2'b00, next_reg, id_reg, status_reg};
        end
    end

endmodule
`default_nettype wire
